FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/hffl_pkg.sv
`timescale 1ns / 1ps

package hffl_pkg;

    localparam int BLOCKS   = 256;
    localparam int HANDLE_W = 8;
    localparam int LINK_W   = HANDLE_W + 1;
    localparam int SIZE_W   = 32;
    localparam int ACTION_W = 2;

    // Null link sits one past the last handle.
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(BLOCKS);

    localparam logic [ACTION_W-1:0] ACT_LINK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UNLINK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODIFY,
        S_LINK,
        S_FINISH
    } state_t;

    function automatic logic is_handle(input logic [LINK_W-1:0] link);
        return link < NIL_LINK;
    endfunction

endpackage

FILE: rtl/head_fit_free_list_top.sv
`timescale 1ns / 1ps
// Head-fit free list of block handles.
// Item channel (item_valid/item_ready): action, block_id, block_size and
// request_size. Link puts a block at the head, or second when the head is
// strictly larger; unlink removes a listed block; get pops the head when
// its size covers request_size.
// Result channel (result_valid/result_ready): granted and granted_block,
// one result per item, granted_block 0 when nothing is granted.
// Each item steps through the states: the transfer cycle issues the link and
// size memory reads, S_MODIFY writes the first link updates, S_LINK writes
// the neighbor links and loads the result register, or S_FINISH loads it
// once the result register is free. A new item is taken only in S_IDLE.
// A result waiting on result_ready does not block the next input transfer;
// the block only holds in its last step while the result register is full.
// Reset empties the list (head null); the link and size memories are left
// as they are and are only read where the list has written them.
module head_fit_free_list_top
    import hffl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [HANDLE_W-1:0] block_id,
    input  logic [SIZE_W-1:0]   block_size,
    input  logic [SIZE_W-1:0]   request_size,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                granted,
    output logic [HANDLE_W-1:0] granted_block
);

    logic [LINK_W-1:0] next_mem [BLOCKS];
    logic [LINK_W-1:0] prev_mem [BLOCKS];
    logic [SIZE_W-1:0] size_mem [BLOCKS];

    state_t state_reg, state_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [ACTION_W-1:0] act_reg;
    logic [HANDLE_W-1:0] blk_reg;
    logic [SIZE_W-1:0]   bsize_reg;
    logic [SIZE_W-1:0]   req_reg;
    logic                case_a_reg, case_a_next;
    logic [LINK_W-1:0]   nb_reg, nb_next;
    logic                grant_reg, grant_next;
    logic [HANDLE_W-1:0] got_reg, got_next;
    logic                result_valid_reg, result_valid_next;
    logic                granted_reg;
    logic [HANDLE_W-1:0] granted_block_reg;

    logic [LINK_W-1:0] next_rd_reg, prev_rd_reg;
    logic [SIZE_W-1:0] size_rd_reg;

    logic                rd_en;
    logic [HANDLE_W-1:0] next_ra, prev_ra, size_ra;
    logic                next_we, prev_we, size_we;
    logic [HANDLE_W-1:0] next_wa, prev_wa, size_wa;
    logic [LINK_W-1:0]   next_wd, prev_wd;
    logic [SIZE_W-1:0]   size_wd;

    logic accept, out_free, load_result;

    assign accept      = item_valid && item_ready;
    assign item_ready  = (state_reg == S_IDLE);
    assign out_free    = !result_valid_reg || result_ready;
    assign load_result = ((state_reg == S_LINK) || (state_reg == S_FINISH)) && out_free;

    assign rd_en   = accept;
    assign next_ra = (action == ACT_UNLINK) ? block_id : head_reg[HANDLE_W-1:0];
    assign prev_ra = block_id;
    assign size_ra = head_reg[HANDLE_W-1:0];

    // Link and size memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (rd_en)
            next_rd_reg <= next_mem[next_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        if (rd_en)
            prev_rd_reg <= prev_mem[prev_ra];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[size_wa] <= size_wd;
        if (rd_en)
            size_rd_reg <= size_mem[size_ra];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_MODIFY;
            end
            S_MODIFY: state_next = S_LINK;
            S_LINK:   state_next = out_free ? S_IDLE : S_FINISH;
            S_FINISH: state_next = out_free ? S_IDLE : S_FINISH;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        next_we     = 1'b0;
        next_wa     = blk_reg;
        next_wd     = NIL_LINK;
        prev_we     = 1'b0;
        prev_wa     = blk_reg;
        prev_wd     = NIL_LINK;
        size_we     = 1'b0;
        size_wa     = blk_reg;
        size_wd     = bsize_reg;
        head_next   = head_reg;
        case_a_next = case_a_reg;
        nb_next     = nb_reg;
        grant_next  = grant_reg;
        got_next    = got_reg;
        case (state_reg)
            S_MODIFY:
            begin
                grant_next = 1'b0;
                got_next   = '0;
                case (act_reg)
                    ACT_LINK:
                    begin
                        // A relinked head skips the size comparison and stays at the head.
                        case_a_next = is_handle(head_reg)
                                      && (head_reg[HANDLE_W-1:0] != blk_reg)
                                      && (size_rd_reg > bsize_reg);
                        nb_next = case_a_next ? next_rd_reg : head_reg;
                        size_we = 1'b1;
                        next_we = 1'b1;
                        next_wd = nb_next;
                        prev_we = 1'b1;
                        prev_wd = case_a_next ? head_reg : NIL_LINK;
                        if (!case_a_next)
                            head_next = {1'b0, blk_reg};
                    end
                    ACT_UNLINK:
                    begin
                        if (is_handle(prev_rd_reg))
                        begin
                            next_we = 1'b1;
                            next_wa = prev_rd_reg[HANDLE_W-1:0];
                            next_wd = next_rd_reg;
                        end
                        else
                        begin
                            head_next = next_rd_reg;
                        end
                        if (is_handle(next_rd_reg))
                        begin
                            prev_we = 1'b1;
                            prev_wa = next_rd_reg[HANDLE_W-1:0];
                            prev_wd = prev_rd_reg;
                        end
                    end
                    ACT_GET:
                    begin
                        if (is_handle(head_reg) && !(size_rd_reg < req_reg))
                        begin
                            grant_next = 1'b1;
                            got_next   = head_reg[HANDLE_W-1:0];
                            head_next  = next_rd_reg;
                            if (is_handle(next_rd_reg))
                            begin
                                prev_we = 1'b1;
                                prev_wa = next_rd_reg[HANDLE_W-1:0];
                                prev_wd = NIL_LINK;
                            end
                        end
                    end
                    default:
                    begin
                        grant_next = 1'b0;
                    end
                endcase
            end
            S_LINK:
            begin
                // Second half of a link: patch the neighbors.
                if (act_reg == ACT_LINK)
                begin
                    if (case_a_reg)
                    begin
                        next_we = 1'b1;
                        next_wa = head_reg[HANDLE_W-1:0];
                        next_wd = {1'b0, blk_reg};
                    end
                    if (is_handle(nb_reg))
                    begin
                        prev_we = 1'b1;
                        prev_wa = nb_reg[HANDLE_W-1:0];
                        prev_wd = {1'b0, blk_reg};
                    end
                end
            end
            default:
            begin
                next_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= NIL_LINK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            blk_reg   <= block_id;
            bsize_reg <= block_size;
            req_reg   <= request_size;
        end
        case_a_reg <= case_a_next;
        nb_reg     <= nb_next;
        grant_reg  <= grant_next;
        got_reg    <= got_next;
        if (load_result)
        begin
            granted_reg       <= grant_reg;
            granted_block_reg <= got_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign granted       = granted_reg;
    assign granted_block = granted_block_reg;

endmodule

FILE: rtl/hffl_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hffl_checker
    import hffl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input logic                granted,
    input logic [HANDLE_W-1:0] granted_block
);

    `ASSERT_IMPL(a_no_grant_zero, result_valid && !granted, granted_block == '0)
    `ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
                 result_valid && $stable(granted) && $stable(granted_block))
    `ASSERT_NEXT(a_busy_after_transfer, item_valid && item_ready, !item_ready)
    `ASSERT_IMPL(a_result_after_transfer, item_valid && item_ready, ##3 result_valid)

endmodule

bind head_fit_free_list_top hffl_checker u_checker (.*);
